/* src/ukdg_pkg.sv */
// Package for the uniform kernel density grid: sizes, opcodes, register indices, FSM states
// and the divider request struct. No dependencies.
package ukdg_pkg;

  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 64;
  localparam int COUNT_WIDTH = 20;

  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int ADDR_W = COL_W + ROW_W;
  localparam int DEPTH  = 1 << ADDR_W;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_ADD      = 2'd1,
    OP_FINALIZE = 2'd2,
    OP_READ     = 2'd3
  } ukdg_op_t;

  typedef enum logic [2:0] {
    REG_X_ORIGIN = 3'd0,
    REG_Y_ORIGIN = 3'd1,
    REG_COL_STEP = 3'd2,
    REG_ROW_STEP = 3'd3,
    REG_HALF_X   = 3'd4,
    REG_HALF_Y   = 3'd5,
    REG_COLS     = 3'd6,
    REG_ROWS     = 3'd7
  } ukdg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_DIV0,
    S_DIV0_W,
    S_DIV1,
    S_DIV1_W,
    S_ROWS,
    S_FIN,
    S_RD_WAIT,
    S_DONE
  } ukdg_state_t;

  typedef struct packed {
    logic        start;
    logic [16:0] num;
    logic [15:0] den;
  } div_req_t;

endpackage

/* src/ukdg_in_if.sv */
// Input channel of the density grid: valid/ready plus the command item.
// Depends on nothing.
interface ukdg_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic [5:0]         cell_column;
  logic [5:0]         cell_row;

  modport source (output valid, opcode, point_x, point_y, cell_column, cell_row,
                  input ready);
  modport sink   (input valid, opcode, point_x, point_y, cell_column, cell_row,
                  output ready);
endinterface

/* src/ukdg_out_if.sv */
// Result channel of the density grid: valid/ready plus the result item.
// Depends on nothing.
interface ukdg_out_if;
  logic               valid;
  logic               ready;
  logic signed [20:0] density_count;
  logic               done_res;

  modport source (output valid, density_count, done_res, input ready);
  modport sink   (input valid, density_count, done_res, output ready);
endinterface

/* src/ukdg_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module ukdg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/ukdg_div.sv */
// Restoring divider, one quotient bit per cycle, 17-bit quotient.
// Depends on ukdg_pkg.
module ukdg_div
  import ukdg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  div_req_t    req,
  output logic        busy,
  output logic        done,
  output logic [16:0] quo
);

  logic [16:0] n_r, n_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [15:0] den_r, den_nxt;
  logic [16:0] acc;
  logic        ge;

  always_comb begin
    acc      = {rem_r, n_r[16]};
    ge       = acc >= {1'b0, den_r};
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    den_nxt  = den_r;
    if (req.start && !busy_r) begin
      n_nxt    = req.num;
      rem_nxt  = '0;
      cnt_nxt  = 5'd17;
      busy_nxt = 1'b1;
      den_nxt  = req.den;
    end else if (busy_r) begin
      // shift in the next numerator bit, subtract when it fits
      rem_nxt = ge ? 16'(acc - {1'b0, den_r}) : acc[15:0];
      n_nxt   = {n_r[15:0], ge};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    n_r   <= n_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = n_r;

endmodule

/* src/uniform_kernel_density_grid_core.sv */
// Uniform kernel density grid, sweep-line build over two 4096 x 20 count RAMs.
// Clear sweeps every entry of both RAMs; add point runs two divides, then one row
// per cycle; finalize walks rows times cols cells; read fetches both counts.
// Throughput is one item at a time, set by the single read-modify-write port
// of each count RAM and the shared serial divider.
// Reset: synchronous active low; after reset both RAMs are swept to zero,
// during which no item is accepted (config writes still work).
module uniform_kernel_density_grid_core
  import ukdg_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  ukdg_in_if.sink       in_ch,
  ukdg_out_if.source    out_ch,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [4:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);

  // ---------------------------------------------------------------- config
  logic [15:0] x_origin_r, y_origin_r, col_step_r, row_step_r, half_x_r, half_y_r;
  logic [6:0]  cols_used_r, rows_used_r;
  logic        cfg_wr;
  ukdg_reg_t   cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = ukdg_reg_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_origin_r  <= 16'd0;
      y_origin_r  <= 16'd0;
      col_step_r  <= 16'd1;
      row_step_r  <= 16'd1;
      half_x_r    <= 16'd1;
      half_y_r    <= 16'd1;
      cols_used_r <= 7'd64;
      rows_used_r <= 7'd64;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_X_ORIGIN: x_origin_r  <= cfg_pwdata[15:0];
        REG_Y_ORIGIN: y_origin_r  <= cfg_pwdata[15:0];
        REG_COL_STEP: col_step_r  <= cfg_pwdata[15:0];
        REG_ROW_STEP: row_step_r  <= cfg_pwdata[15:0];
        REG_HALF_X:   half_x_r    <= cfg_pwdata[15:0];
        REG_HALF_Y:   half_y_r    <= cfg_pwdata[15:0];
        REG_COLS:     cols_used_r <= cfg_pwdata[6:0];
        REG_ROWS:     rows_used_r <= cfg_pwdata[6:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_X_ORIGIN: cfg_prdata = {16'd0, x_origin_r};
      REG_Y_ORIGIN: cfg_prdata = {16'd0, y_origin_r};
      REG_COL_STEP: cfg_prdata = {16'd0, col_step_r};
      REG_ROW_STEP: cfg_prdata = {16'd0, row_step_r};
      REG_HALF_X:   cfg_prdata = {16'd0, half_x_r};
      REG_HALF_Y:   cfg_prdata = {16'd0, half_y_r};
      REG_COLS:     cfg_prdata = {25'd0, cols_used_r};
      REG_ROWS:     cfg_prdata = {25'd0, rows_used_r};
    endcase
  end

  // Effective grid size, clamped to 1..MAX; kept as last index.
  logic [COL_W-1:0] cols_m1;
  logic [ROW_W-1:0] rows_m1;
  logic [15:0]      sx, sy;

  always_comb begin
    int c, r;
    c = int'(cols_used_r);
    r = int'(rows_used_r);
    if (c < 1) c = 1;
    if (c > MAX_COLUMNS) c = MAX_COLUMNS;
    if (r < 1) r = 1;
    if (r > MAX_ROWS) r = MAX_ROWS;
    cols_m1 = COL_W'(c - 1);
    rows_m1 = ROW_W'(r - 1);
  end

  // a zero step acts as one
  assign sx = (col_step_r == 16'd0) ? 16'd1 : col_step_r;
  assign sy = (row_step_r == 16'd0) ? 16'd1 : row_step_r;

  // ---------------------------------------------------------------- RAMs
  logic                   we;
  logic [ADDR_W-1:0]      waddr_u, waddr_l, raddr_u, raddr_l;
  logic [COUNT_WIDTH-1:0] wdata_u, wdata_l, rdata_u, rdata_l;
  logic                   we_u, we_l;

  ukdg_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(DEPTH)) u_upper (
    .clk(clk), .we(we_u), .waddr(waddr_u), .wdata(wdata_u),
    .raddr(raddr_u), .rdata(rdata_u)
  );

  ukdg_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(DEPTH)) u_lower (
    .clk(clk), .we(we_l), .waddr(waddr_l), .wdata(wdata_l),
    .raddr(raddr_l), .rdata(rdata_l)
  );

  assign we = we_u || we_l;

  // ---------------------------------------------------------------- divider
  div_req_t    div_req;
  logic        div_busy, div_done;
  logic [16:0] div_quo;

  ukdg_div u_div (
    .clk(clk), .rst_n(rst_n), .req(div_req),
    .busy(div_busy), .done(div_done), .quo(div_quo)
  );

  // ---------------------------------------------------------------- control
  ukdg_state_t state_r, state_nxt;
  logic        from_reset_r, from_reset_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;

  // add-point working registers
  logic signed [17:0] n_en_r, n_en_nxt, n_ex_r, n_ex_nxt;
  logic signed [24:0] d_r, d_nxt;
  logic [COL_W-1:0]   entry_r, entry_nxt, exit_r, exit_nxt;
  logic [ROW_W-1:0]   j_r, j_nxt;

  // finalize counters and running sums
  logic [COL_W-1:0]       fi_r, fi_nxt;
  logic                   f_v_r, f_v_nxt, f_first_r, f_first_nxt;
  logic [ADDR_W-1:0]      f_addr_r, f_addr_nxt;
  logic [COUNT_WIDTH-1:0] run_u_r, run_u_nxt, run_l_r, run_l_nxt;

  // add pipeline: one read stage, write back next cycle
  logic              p_v_r, p_v_nxt;
  logic [ADDR_W-1:0] p_au_r, p_au_nxt, p_al_r, p_al_nxt;

  logic        rd_ok_r, rd_ok_nxt;
  logic [20:0] res_r, res_nxt;
  logic        out_v_r, out_v_nxt;
  logic [20:0] out_d_r, out_d_nxt;

  logic               in_acc;
  logic signed [17:0] nx;
  logic signed [24:0] by_s;
  logic               hit;
  logic [COL_W-1:0]   div_col;
  logic [COUNT_WIDTH:0] sum_u, sum_l;
  logic [63:0]          diff;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign nx   = {{2{in_ch.point_x[15]}}, in_ch.point_x} - {{2{x_origin_r[15]}}, x_origin_r};
  assign by_s = {9'd0, half_y_r};
  assign hit  = (d_r >= -by_s) && (d_r < by_s);

  // clamp the quotient to the last column in use
  assign div_col = ({15'd0, div_quo} > 32'(cols_m1)) ? cols_m1 : COL_W'(div_quo);

  assign sum_u = {1'b0, rdata_u} + {1'b0, run_u_r};
  assign sum_l = {1'b0, rdata_l} + {1'b0, run_l_r};
  assign diff  = 64'(rdata_u) - 64'(rdata_l);

  always_comb begin
    state_nxt      = state_r;
    from_reset_nxt = from_reset_r;
    clr_nxt        = clr_r;
    n_en_nxt       = n_en_r;
    n_ex_nxt       = n_ex_r;
    d_nxt          = d_r;
    entry_nxt      = entry_r;
    exit_nxt       = exit_r;
    j_nxt          = j_r;
    fi_nxt         = fi_r;
    f_v_nxt        = 1'b0;
    f_first_nxt    = f_first_r;
    f_addr_nxt     = f_addr_r;
    run_u_nxt      = run_u_r;
    run_l_nxt      = run_l_r;
    p_v_nxt        = 1'b0;
    p_au_nxt       = p_au_r;
    p_al_nxt       = p_al_r;
    rd_ok_nxt      = rd_ok_r;
    res_nxt        = res_r;
    out_v_nxt      = out_v_r && !out_ch.ready;
    out_d_nxt      = out_d_r;
    div_req        = '{start: 1'b0, num: 17'd0, den: sx};
    raddr_u        = '0;
    raddr_l        = '0;
    we_u           = 1'b0;
    we_l           = 1'b0;
    waddr_u        = '0;
    waddr_l        = '0;
    wdata_u        = '0;
    wdata_l        = '0;

    // write back of the add pipeline: saturating increment
    if (p_v_r) begin
      we_u    = 1'b1;
      we_l    = 1'b1;
      waddr_u = p_au_r;
      waddr_l = p_al_r;
      wdata_u = (rdata_u == COUNT_MAX) ? rdata_u : rdata_u + 1'b1;
      wdata_l = (rdata_l == COUNT_MAX) ? rdata_l : rdata_l + 1'b1;
    end

    // finalize data stage: load or accumulate the running row sum
    if (f_v_r) begin
      if (f_first_r) begin
        run_u_nxt = rdata_u;
        run_l_nxt = rdata_l;
      end else begin
        run_u_nxt = sum_u[COUNT_WIDTH] ? COUNT_MAX : sum_u[COUNT_WIDTH-1:0];
        run_l_nxt = sum_l[COUNT_WIDTH] ? COUNT_MAX : sum_l[COUNT_WIDTH-1:0];
        we_u      = 1'b1;
        we_l      = 1'b1;
        waddr_u   = f_addr_r;
        waddr_l   = f_addr_r;
        wdata_u   = run_u_nxt;
        wdata_l   = run_l_nxt;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_nxt = 21'd0;
          unique case (ukdg_op_t'(in_ch.opcode))
            OP_CLEAR: begin
              clr_nxt   = '0;
              state_nxt = S_CLEAR;
            end
            OP_ADD: begin
              n_en_nxt  = nx - {2'b0, half_x_r};
              n_ex_nxt  = nx + {2'b0, half_x_r};
              d_nxt     = {{9{in_ch.point_y[15]}}, in_ch.point_y}
                          - {{9{y_origin_r[15]}}, y_origin_r};
              j_nxt     = '0;
              state_nxt = S_DIV0;
            end
            OP_FINALIZE: begin
              fi_nxt    = '0;
              j_nxt     = '0;
              state_nxt = S_FIN;
            end
            OP_READ: begin
              raddr_u   = {COL_W'(in_ch.cell_column), ROW_W'(in_ch.cell_row)};
              raddr_l   = raddr_u;
              rd_ok_nxt = (32'(in_ch.cell_column) < MAX_COLUMNS)
                          && (32'(in_ch.cell_row) < MAX_ROWS);
              state_nxt = S_RD_WAIT;
            end
          endcase
        end
      end
      S_CLEAR: begin
        we_u    = 1'b1;
        we_l    = 1'b1;
        waddr_u = clr_r;
        waddr_l = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == {ADDR_W{1'b1}}) begin
          from_reset_nxt = 1'b0;
          state_nxt      = from_reset_r ? S_IDLE : S_DONE;
        end
      end
      S_DIV0: begin
        // column of ceil(n/s) - 1 equals floor((n-1)/s) for positive n
        div_req.start = 1'b1;
        div_req.num   = 17'(n_en_r - 18'sd1);
        state_nxt     = S_DIV0_W;
      end
      S_DIV0_W: begin
        if (div_done) begin
          entry_nxt = (n_en_r > 18'sd0) ? div_col : '0;
          state_nxt = S_DIV1;
        end
      end
      S_DIV1: begin
        div_req.start = 1'b1;
        div_req.num   = 17'(n_ex_r - 18'sd1);
        state_nxt     = S_DIV1_W;
      end
      S_DIV1_W: begin
        if (div_done) begin
          exit_nxt  = (n_ex_r > 18'sd0) ? div_col : '0;
          state_nxt = S_ROWS;
        end
      end
      S_ROWS: begin
        // one row per cycle; rows differ, so read and write back never collide
        if (hit) begin
          raddr_u  = {entry_r, j_r};
          raddr_l  = {exit_r, j_r};
          p_v_nxt  = 1'b1;
          p_au_nxt = raddr_u;
          p_al_nxt = raddr_l;
        end
        d_nxt = d_r - {9'd0, sy};
        j_nxt = j_r + 1'b1;
        if (j_r == rows_m1) begin
          state_nxt = S_DONE;
        end
      end
      S_FIN: begin
        // walk each row left to right; each entry is read before it is written
        raddr_u     = {fi_r, j_r};
        raddr_l     = raddr_u;
        f_v_nxt     = 1'b1;
        f_first_nxt = (fi_r == '0);
        f_addr_nxt  = raddr_u;
        if (fi_r == cols_m1) begin
          fi_nxt = '0;
          j_nxt  = j_r + 1'b1;
          if (j_r == rows_m1) begin
            state_nxt = S_DONE;
          end
        end else begin
          fi_nxt = fi_r + 1'b1;
        end
      end
      S_RD_WAIT: begin
        res_nxt   = rd_ok_r ? diff[20:0] : 21'd0;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_v_r || out_ch.ready) begin
          out_v_nxt = 1'b1;
          out_d_nxt = res_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      from_reset_r <= 1'b1;
      clr_r        <= '0;
      p_v_r        <= 1'b0;
      f_v_r        <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      from_reset_r <= from_reset_nxt;
      clr_r        <= clr_nxt;
      p_v_r        <= p_v_nxt;
      f_v_r        <= f_v_nxt;
      out_v_r      <= out_v_nxt;
    end
    n_en_r    <= n_en_nxt;
    n_ex_r    <= n_ex_nxt;
    d_r       <= d_nxt;
    entry_r   <= entry_nxt;
    exit_r    <= exit_nxt;
    j_r       <= j_nxt;
    fi_r      <= fi_nxt;
    f_first_r <= f_first_nxt;
    f_addr_r  <= f_addr_nxt;
    run_u_r   <= run_u_nxt;
    run_l_r   <= run_l_nxt;
    p_au_r    <= p_au_nxt;
    p_al_r    <= p_al_nxt;
    rd_ok_r   <= rd_ok_nxt;
    res_r     <= res_nxt;
    out_d_r   <= out_d_nxt;
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.density_count = out_d_r;
  assign out_ch.done_res      = 1'b1;

`ifndef SYNTH
  // no RAM write while waiting for a command
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !we)
    else $error("count RAM written while idle");

  // an accepted item always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("accepted item did not start work");

  // divider is started only when free
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_busy)
    else $error("divider started while busy");
`endif

endmodule

/* tb/uniform_kernel_density_grid_core_tb.sv */
// Testbench for uniform_kernel_density_grid_core: directed table, edge-case grids, then random phases
// checked against a sweep-line grid predictor. Depends on ukdg_pkg and the two channel ifs.
`timescale 1ns / 1ps

module uniform_kernel_density_grid_core_tb;
  import ukdg_pkg::*;

  localparam int STALL_LIMIT = 40000;

  typedef struct {
    ukdg_op_t           op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [5:0]         col;
    logic [5:0]         row;
    bit                 typed;
    logic [20:0]        count;
  } cmd_t;

  typedef struct {
    logic [20:0] count;
    logic        done;
  } density_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic        cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  ukdg_in_if  in_ch();
  ukdg_out_if out_ch();

  uniform_kernel_density_grid_core DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: grid settings as the block holds them, plus both count stores
  logic signed [15:0] x_org, y_org;
  logic [15:0]        col_step, row_step, half_x, half_y;
  logic [6:0]         cols_reg, rows_reg;
  logic [COUNT_WIDTH-1:0] upper_grid [DEPTH];
  logic [COUNT_WIDTH-1:0] lower_grid [DEPTH];

  density_t pending_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int out_stall = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_CLEAR;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.cell_column = '0;
    in_ch.cell_row = '0;
    out_ch.ready = 1'b0;
  end

  task automatic report(input string what, input logic [20:0] got, input logic [20:0] want);
    errors++;
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  function automatic int eff_cols();
    if (cols_reg < 1) return 1;
    if (cols_reg > MAX_COLUMNS) return MAX_COLUMNS;
    return cols_reg;
  endfunction

  function automatic int eff_rows();
    if (rows_reg < 1) return 1;
    if (rows_reg > MAX_ROWS) return MAX_ROWS;
    return rows_reg;
  endfunction

  // Ceil division toward +inf, then clamp to 0..cols and step down one
  function automatic longint edge_col(longint num, longint step, longint cols);
    longint c;
    c = (num >= 0) ? (num + step - 1) / step : -((-num) / step);
    if (c > cols) c = cols;
    if (c < 0) c = 0;
    if (c != 0) c = c - 1;
    return c;
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] sat_sum(logic [COUNT_WIDTH-1:0] a,
                                                    logic [COUNT_WIDTH-1:0] b);
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_WIDTH] ? COUNT_MAX : s[COUNT_WIDTH-1:0];
  endfunction

  function automatic void clear_grid();
    for (int k = 0; k < DEPTH; k++) begin
      upper_grid[k] = '0;
      lower_grid[k] = '0;
    end
  endfunction

  // Advance the predicted stores by one item and return the expected count
  function automatic logic [20:0] density_predict(cmd_t c);
    longint sx, sy, entry, exitc, centre, px, py, hx, hy;
    int k;
    sx = (col_step == 0) ? 1 : col_step;
    sy = (row_step == 0) ? 1 : row_step;
    px = longint'(c.x);
    py = longint'(c.y);
    hx = longint'(half_x);
    hy = longint'(half_y);
    case (c.op)
      OP_CLEAR: clear_grid();
      OP_ADD: begin
        entry = edge_col(px - longint'(x_org) - hx, sx, eff_cols());
        exitc = edge_col(px - longint'(x_org) + hx, sx, eff_cols());
        for (int j = 0; j < eff_rows(); j++) begin
          centre = longint'(y_org) + j * sy;
          if (py >= centre - hy && py < centre + hy) begin
            upper_grid[entry*MAX_ROWS+j] = sat_sum(upper_grid[entry*MAX_ROWS+j], 1);
            lower_grid[exitc*MAX_ROWS+j] = sat_sum(lower_grid[exitc*MAX_ROWS+j], 1);
          end
        end
      end
      OP_FINALIZE: begin
        for (int i = 1; i < eff_cols(); i++)
          for (int j = 0; j < eff_rows(); j++) begin
            upper_grid[i*MAX_ROWS+j] = sat_sum(upper_grid[i*MAX_ROWS+j],
                                               upper_grid[(i-1)*MAX_ROWS+j]);
            lower_grid[i*MAX_ROWS+j] = sat_sum(lower_grid[i*MAX_ROWS+j],
                                               lower_grid[(i-1)*MAX_ROWS+j]);
          end
      end
      default: begin
        k = c.col * MAX_ROWS + c.row;
        return {1'b0, upper_grid[k]} - {1'b0, lower_grid[k]};
      end
    endcase
    return '0;
  endfunction

  // Half the time no gap, otherwise mostly short gaps and a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Drive one item; valid stays high after acceptance unless a gap follows
  task automatic send_cmd(cmd_t c);
    density_t e;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= c.op;
    in_ch.point_x <= c.x;
    in_ch.point_y <= c.y;
    in_ch.cell_column <= c.col;
    in_ch.cell_row <= c.row;
    do @(posedge clk); while (!in_ch.ready);
    e.count = density_predict(c);
    if (c.typed) e.count = c.count;
    e.done = 1'b1;
    pending_q.push_back(e);
  endtask

  // Register write while idle: drop valid, drain results, then setup and access
  task automatic cfg_write(ukdg_reg_t idx, logic [15:0] val);
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {16'h0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_X_ORIGIN: x_org = val;
      REG_Y_ORIGIN: y_org = val;
      REG_COL_STEP: col_step = val;
      REG_ROW_STEP: row_step = val;
      REG_HALF_X:   half_x = val;
      REG_HALF_Y:   half_y = val;
      REG_COLS:     cols_reg = val[6:0];
      default:      rows_reg = val[6:0];
    endcase
  endtask

  function automatic cmd_t mk(ukdg_op_t op, int x, int y, int col, int row);
    cmd_t c;
    c.op = op;
    c.x = x[15:0];
    c.y = y[15:0];
    c.col = col[5:0];
    c.row = row[5:0];
    c.typed = 1'b0;
    c.count = '0;
    return c;
  endfunction

  function automatic cmd_t mk_typed(ukdg_op_t op, int x, int y, int col, int row,
                                    logic [20:0] want);
    cmd_t c;
    c = mk(op, x, y, col, row);
    c.typed = 1'b1;
    c.count = want;
    return c;
  endfunction

  // Result side: random stalls, compare each accepted item with the oldest expectation
  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) begin
        report("unexpected item", out_ch.density_count, '0);
      end else begin
        if (out_ch.density_count !== pending_q[0].count)
          report("density_count", out_ch.density_count, pending_q[0].count);
        if (out_ch.done_res !== pending_q[0].done)
          report("done_res", out_ch.done_res, pending_q[0].done);
        void'(pending_q.pop_front());
      end
    end
    if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_stall <= pick_gap();
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic set_grid(int ox, int oy, int sx, int sy, int bx, int by, int nc, int nr);
    cfg_write(REG_X_ORIGIN, ox[15:0]);
    cfg_write(REG_Y_ORIGIN, oy[15:0]);
    cfg_write(REG_COL_STEP, sx[15:0]);
    cfg_write(REG_ROW_STEP, sy[15:0]);
    cfg_write(REG_HALF_X, bx[15:0]);
    cfg_write(REG_HALF_Y, by[15:0]);
    cfg_write(REG_COLS, nc[15:0]);
    cfg_write(REG_ROWS, nr[15:0]);
  endtask

  initial begin
    cmd_t dir_tab[$];
    cmd_t c;
    int sent, n_adds, nc, nr, sx, sy, bx, by, ox, oy, r;

    x_org = 0; y_org = 0; col_step = 1; row_step = 1;
    half_x = 1; half_y = 1; cols_reg = 64; rows_reg = 64;
    clear_grid();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty reads, clear, extreme points, two finalizes and reads back
    dir_tab.push_back(mk_typed(OP_READ, 0, 0, 0, 0, 21'd0));
    dir_tab.push_back(mk_typed(OP_READ, 0, 0, 63, 63, 21'd0));
    dir_tab.push_back(mk_typed(OP_CLEAR, 0, 0, 0, 0, 21'd0));
    dir_tab.push_back(mk_typed(OP_ADD, 0, 0, 0, 0, 21'd0));
    dir_tab.push_back(mk_typed(OP_ADD, -32768, -32768, 0, 0, 21'd0));
    dir_tab.push_back(mk_typed(OP_ADD, 32767, 32767, 63, 63, 21'd0));
    dir_tab.push_back(mk_typed(OP_ADD, 5, 3, 0, 0, 21'd0));
    dir_tab.push_back(mk_typed(OP_ADD, 63, 62, 0, 0, 21'd0));
    dir_tab.push_back(mk(OP_READ, 0, 0, 3, 3));
    dir_tab.push_back(mk(OP_READ, 0, 0, 5, 4));
    dir_tab.push_back(mk_typed(OP_FINALIZE, 0, 0, 0, 0, 21'd0));
    dir_tab.push_back(mk(OP_READ, 0, 0, 4, 3));
    dir_tab.push_back(mk(OP_READ, 0, 0, 0, 0));
    dir_tab.push_back(mk(OP_READ, 0, 0, 63, 63));
    dir_tab.push_back(mk(OP_READ, 0, 0, 63, 0));
    dir_tab.push_back(mk_typed(OP_FINALIZE, 0, 0, 0, 0, 21'd0));
    dir_tab.push_back(mk(OP_READ, 0, 0, 10, 3));
    foreach (dir_tab[i]) send_cmd(dir_tab[i]);

    // Zero steps and out-of-range grid sizes, exercised before the random part
    set_grid(-32768, 32767, 0, 0, 0, 65535, 0, 127);
    send_cmd(mk(OP_ADD, -32768, 100, 0, 0));
    send_cmd(mk(OP_ADD, -32767, -32768, 0, 0));
    send_cmd(mk(OP_FINALIZE, 0, 0, 0, 0));
    send_cmd(mk(OP_READ, 0, 0, 0, 0));
    send_cmd(mk(OP_READ, 0, 0, 0, 63));

    // Saturation: one row, many finalizes over the full width
    set_grid(0, 0, 1, 1, 65535, 1, 64, 1);
    send_cmd(mk(OP_CLEAR, 0, 0, 0, 0));
    repeat (4) send_cmd(mk(OP_ADD, 0, 0, 0, 0));
    repeat (14) send_cmd(mk(OP_FINALIZE, 0, 0, 0, 0));
    send_cmd(mk(OP_READ, 0, 0, 63, 0));
    send_cmd(mk(OP_READ, 0, 0, 20, 0));

    // Random phases: settle a grid, sometimes clear, add mostly well-formed points, finalize, read back
    sent = 0;
    while (sent < 600) begin
      r = $urandom_range(0, 9);
      nc = (r < 2) ? $urandom_range(0, 127) : $urandom_range(1, 12);
      nr = (r < 2) ? $urandom_range(0, 127) : $urandom_range(1, 12);
      sx = (r == 3) ? $urandom_range(0, 65535) : $urandom_range(0, 40);
      sy = (r == 4) ? $urandom_range(0, 65535) : $urandom_range(0, 40);
      bx = (r == 5) ? $urandom_range(0, 65535) : $urandom_range(0, 60);
      by = (r == 6) ? $urandom_range(0, 65535) : $urandom_range(0, 60);
      ox = $urandom_range(0, 65535) - 32768;
      oy = $urandom_range(0, 65535) - 32768;
      set_grid(ox, oy, sx, sy, bx, by, nc, nr);
      if ($urandom_range(0, 2) == 0) begin
        send_cmd(mk(OP_CLEAR, 0, 0, 0, 0));
        sent++;
      end
      n_adds = $urandom_range(4, 30);
      for (int i = 0; i < n_adds; i++) begin
        if ($urandom_range(0, 9) < 8)
          c = mk(OP_ADD, ox + $urandom_range(0, (sx + 1) * 13) - bx,
                 oy + $urandom_range(0, (sy + 1) * 13) - by, 0, 0);
        else
          c = mk(ukdg_op_t'($urandom_range(1, 3)), $urandom, $urandom,
                 $urandom_range(0, 63), $urandom_range(0, 63));
        send_cmd(c);
        sent++;
      end
      repeat ($urandom_range(1, 2)) begin
        send_cmd(mk(OP_FINALIZE, 0, 0, 0, 0));
        sent++;
      end
      repeat ($urandom_range(8, 30)) begin
        r = $urandom_range(0, 9);
        send_cmd(mk(OP_READ, $urandom, $urandom,
                    (r < 7) ? $urandom_range(0, 13) : $urandom_range(0, 63),
                    (r < 7) ? $urandom_range(0, 13) : $urandom_range(0, 63)));
        sent++;
      end
    end

    // Drain, then allow the last item to settle
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
src/ukdg_pkg.sv
src/ukdg_in_if.sv
src/ukdg_out_if.sv
src/ukdg_ram.sv
src/ukdg_div.sv
src/uniform_kernel_density_grid_core.sv
tb/uniform_kernel_density_grid_core_tb.sv
